### rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants of the state envelope deframer
// Holds the parse phase encoding, register indexes, reset values and the
// beat structs that pass between the parser and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

  // Reset values of the configuration registers.
  localparam logic [31:0] MagicReset   = 32'h3354_534E;
  localparam logic [7:0]  VersionReset = 8'h01;

  // Width of the register index on the configuration channel.
  localparam int unsigned CfgIdxW = 8;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MAGIC   = 8'd0,
    REG_VERSION = 8'd1
  } cfg_reg_e;

  // Parse phases of one envelope.
  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_VERSION = 3'd1,
    PH_COMPLEN = 3'd2,
    PH_COMP    = 3'd3,
    PH_CTRLLEN = 3'd4,
    PH_CTRL    = 3'd5,
    PH_END     = 3'd6
  } phase_e;

  // Section tags on payload bytes.
  localparam logic SecComponent  = 1'b0;
  localparam logic SecController = 1'b1;

  // One input beat.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } sed_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       payload_valid;
    logic       section;
    logic       frame_done;
    logic       frame_ok;
  } sed_result_t;

endpackage : sed_pkg

`default_nettype wire

### rtl/sed_parser.sv
// ----------------------------------------------------------------------------
// sed_parser: envelope parse state and per-byte decode
// Keeps the frame state and, for the beat in the input register, works out
// the result and the next state in one pass of short logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_parser (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  sed_pkg::sed_item_t    item_i,
  input  wire [31:0]            magic_word_i,
  input  wire [7:0]             format_version_i,
  output sed_pkg::sed_result_t  result_o
);
  import sed_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [23:0] acc_q, acc_d;
  logic [31:0] remain_q, remain_d;
  logic        rejected_q, rejected_d;

  logic [7:0]  b;
  logic [7:0]  magic_byte;
  logic [31:0] length;
  logic [23:0] acc_merged;
  logic        pv;
  logic        sec;

  assign b = item_i.in_byte;

  // Expected magic byte for the current position.
  always_comb begin
    case (idx_q)
      2'd0:    magic_byte = magic_word_i[7:0];
      2'd1:    magic_byte = magic_word_i[15:8];
      2'd2:    magic_byte = magic_word_i[23:16];
      default: magic_byte = magic_word_i[31:24];
    endcase
  end

  // Length field assembly: the top byte completes the word.
  always_comb begin
    acc_merged = acc_q;
    case (idx_q)
      2'd0:    acc_merged[7:0]   = b;
      2'd1:    acc_merged[15:8]  = b;
      2'd2:    acc_merged[23:16] = b;
      default: acc_merged        = acc_q;
    endcase
  end
  assign length = {b, acc_q};

  // Next state and payload tagging for one byte.
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    remain_d   = remain_q;
    rejected_d = rejected_q;
    pv         = 1'b0;
    sec        = SecComponent;
    if (!rejected_q) begin
      case (phase_q)
        PH_MAGIC: begin
          if (b != magic_byte) begin
            rejected_d = 1'b1;
          end else if (idx_q == 2'd3) begin
            idx_d   = 2'd0;
            phase_d = PH_VERSION;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
        PH_VERSION: begin
          if (b != format_version_i) begin
            rejected_d = 1'b1;
          end else begin
            phase_d = PH_COMPLEN;
          end
        end
        PH_COMPLEN, PH_CTRLLEN: begin
          if (idx_q == 2'd3) begin
            remain_d = length;
            acc_d    = '0;
            idx_d    = 2'd0;
            if (phase_q == PH_COMPLEN) begin
              phase_d = (length == '0) ? PH_CTRLLEN : PH_COMP;
            end else begin
              phase_d = (length == '0) ? PH_END : PH_CTRL;
            end
          end else begin
            acc_d = acc_merged;
            idx_d = idx_q + 2'd1;
          end
        end
        PH_COMP, PH_CTRL: begin
          pv       = 1'b1;
          sec      = (phase_q == PH_CTRL) ? SecController : SecComponent;
          remain_d = remain_q - 32'd1;
          if (remain_q == 32'd1) begin
            phase_d = (phase_q == PH_CTRL) ? PH_END : PH_CTRLLEN;
          end
        end
        PH_END: begin
          // Bytes past the controller payload reject the frame.
          rejected_d = 1'b1;
        end
        default: begin
          rejected_d = 1'b1;
        end
      endcase
    end

    // Result for this byte.
    result_o.out_byte      = pv ? b : 8'd0;
    result_o.payload_valid = pv;
    result_o.section       = pv ? sec : SecComponent;
    result_o.frame_done    = item_i.final_byte;
    result_o.frame_ok      = item_i.final_byte && !rejected_d && (phase_d == PH_END);

    // The final byte closes the frame and rearms the parser.
    if (item_i.final_byte) begin
      phase_d    = PH_MAGIC;
      idx_d      = 2'd0;
      acc_d      = '0;
      remain_d   = '0;
      rejected_d = 1'b0;
    end
  end

  // Frame state registers, advanced once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      idx_q      <= 2'd0;
      acc_q      <= '0;
      remain_q   <= '0;
      rejected_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      acc_q      <= acc_d;
      remain_q   <= remain_d;
      rejected_q <= rejected_d;
    end
  end

  // A final byte always rearms the parser for the next frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.final_byte |=> phase_q == PH_MAGIC && !rejected_q && idx_q == 2'd0)
    else $error("parser not rearmed after final byte");

  // A payload phase never sits with nothing left to count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rejected_q && (phase_q == PH_COMP || phase_q == PH_CTRL) |-> remain_q != '0)
    else $error("payload phase with zero bytes remaining");

  // A frame is accepted only on its final byte and only if it was never rejected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.frame_ok |-> result_o.frame_done && !rejected_q)
    else $error("frame accepted without final byte or after rejection");

endmodule : sed_parser

`default_nettype wire

### rtl/state_envelope_deframer.sv
// ----------------------------------------------------------------------------
// state_envelope_deframer: byte-stream envelope parser
// Checks magic and version, collects the two section lengths and tags the
// payload bytes of each envelope with their section.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one envelope byte per beat, with tlast on the
//   final byte of the buffer. The master stream returns exactly one result
//   beat per input beat: the payload byte with tuser flags, and on the final
//   byte tlast plus the accept bit in tdata[8].
//   A beat passes an input register, then the parse logic, then a result
//   register: the result beat shows on the master side once the result
//   register has captured it, and one beat is taken every cycle while the
//   master side drains. The parse state is a single pass per byte, so
//   throughput is one byte per clock while the receiver keeps up.
//   When the receiver stalls, the result register holds and the input
//   register holds one more beat; after that s_axis_tready drops.
//   Configuration writes (magic word, version byte) are always ready and are
//   meant for idle periods between frames.
//   Reset returns the parser to the magic phase, empties both registers and
//   loads the default magic and version.
// ----------------------------------------------------------------------------
`default_nettype none

module state_envelope_deframer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Input stream
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [7:0]                   s_axis_tdata,   // [7:0] in_byte
  input  wire                          s_axis_tlast,   // final_byte
  // Result stream
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [7:0] out_byte, [8] frame_ok
  output logic [1:0]                   m_axis_tuser,   // [0] payload_valid, [1] section
  output logic                         m_axis_tlast,   // frame_done
  // Configuration writes
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [sed_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [31:0]                  cfg_data_i
);
  import sed_pkg::*;

  logic        in_vld_q;
  sed_item_t   in_item_q;
  logic        out_vld_q;
  sed_result_t out_res_q;
  sed_result_t res;
  logic        out_free;
  logic        step;
  logic        s_accept;
  logic [31:0] magic_q;
  logic [7:0]  version_q;

  // Pipeline flow control.
  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MagicReset;
      version_q <= VersionReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MAGIC:   magic_q   <= cfg_data_i;
        REG_VERSION: version_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_accept) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.in_byte    <= s_axis_tdata;
      in_item_q.final_byte <= s_axis_tlast;
    end
  end

  sed_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .item_i           (in_item_q),
    .magic_word_i     (magic_q),
    .format_version_i (version_q),
    .result_o         (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  // Result beat packing.
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_res_q.frame_ok, out_res_q.out_byte};
  assign m_axis_tuser  = {out_res_q.section, out_res_q.payload_valid};
  assign m_axis_tlast  = out_res_q.frame_done;

endmodule : state_envelope_deframer

`default_nettype wire

### bench/tb_state_envelope_deframer.sv
// ----------------------------------------------------------------------------
// tb_state_envelope_deframer: self-checking bench for the envelope deframer
// Drives envelopes byte by byte on the input stream, with a directed opening
// and then mostly well-formed frames with random payloads, broken frames and
// noise under several register settings. A scoreboard predicts each result
// beat and compares it, field by field, against the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_state_envelope_deframer;

  import sed_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseItems   = 95;
  localparam int unsigned NumPhases    = 5;
  localparam int unsigned MaxLen       = 64;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned PrintLimit   = 60;
  localparam int unsigned IdxMax       = (1 << CfgIdxW) - 1;

  // Predicts the result beat of every accepted byte and checks the results.
  class envelope_checker;
    logic [31:0]   magic;
    logic [7:0]    version;
    phase_e        phase;
    logic [1:0]    byte_idx;
    logic [31:0]   acc;
    logic [31:0]   remaining;
    logic          rejected;
    sed_result_t   pending[$];
    int unsigned   errors;
    int unsigned   beat_no;

    function new();
      magic   = MagicReset;
      version = VersionReset;
      errors  = 0;
      beat_no = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase     = PH_MAGIC;
      byte_idx  = '0;
      acc       = '0;
      remaining = '0;
      rejected  = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      if (idx == REG_MAGIC) begin
        magic = data;
      end else if (idx == REG_VERSION) begin
        version = data[7:0];
      end
    endfunction

    // Gathers one byte of a little-endian length; true once all four are in.
    function bit take_length_byte(logic [7:0] b);
      acc |= 32'(b) << (8 * byte_idx);
      if (byte_idx == 2'd3) begin
        remaining = acc;
        acc       = '0;
        byte_idx  = '0;
        return 1'b1;
      end
      byte_idx++;
      return 1'b0;
    endfunction

    function void note_input(logic [7:0] b, logic fin);
      sed_result_t r;
      r = '0;
      if (!rejected) begin
        case (phase)
          PH_MAGIC: begin
            if (b != magic[8*byte_idx +: 8]) begin
              rejected = 1'b1;
            end else if (byte_idx == 2'd3) begin
              byte_idx = '0;
              phase    = PH_VERSION;
            end else begin
              byte_idx++;
            end
          end
          PH_VERSION: begin
            if (b != version) rejected = 1'b1;
            else phase = PH_COMPLEN;
          end
          PH_COMPLEN: begin
            if (take_length_byte(b)) begin
              if (remaining == 0) phase = PH_CTRLLEN;
              else phase = PH_COMP;
            end
          end
          PH_COMP: begin
            r.payload_valid = 1'b1;
            r.section       = SecComponent;
            r.out_byte      = b;
            remaining--;
            if (remaining == 0) phase = PH_CTRLLEN;
          end
          PH_CTRLLEN: begin
            if (take_length_byte(b)) begin
              if (remaining == 0) phase = PH_END;
              else phase = PH_CTRL;
            end
          end
          PH_CTRL: begin
            r.payload_valid = 1'b1;
            r.section       = SecController;
            r.out_byte      = b;
            remaining--;
            if (remaining == 0) phase = PH_END;
          end
          default: begin
            // Any byte once the controller payload is complete spoils the frame.
            rejected = 1'b1;
          end
        endcase
      end
      if (fin) begin
        r.frame_done = 1'b1;
        r.frame_ok   = !rejected && (phase == PH_END);
        clear_frame();
      end
      pending = {pending, r};
    endfunction

    task report_mismatch(string msg);
      if (errors < PrintLimit) $display("mismatch: beat %0d: %s", beat_no, msg);
      errors++;
    endtask

    task check_result(sed_result_t got);
      sed_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result beat with no byte outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.out_byte != want.out_byte)
        report_mismatch($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
      if (got.payload_valid != want.payload_valid)
        report_mismatch($sformatf("payload_valid %b, expected %b",
                                  got.payload_valid, want.payload_valid));
      if (got.section != want.section)
        report_mismatch($sformatf("section %b, expected %b", got.section, want.section));
      if (got.frame_done != want.frame_done)
        report_mismatch($sformatf("frame_done %b, expected %b",
                                  got.frame_done, want.frame_done));
      if (got.frame_ok != want.frame_ok)
        report_mismatch($sformatf("frame_ok %b, expected %b", got.frame_ok, want.frame_ok));
      beat_no++;
    endtask

    task check_drained();
      if (pending.size() != 0)
        report_mismatch($sformatf("%0d result beats never arrived", pending.size()));
    endtask
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata   = '0;
  logic                s_axis_tlast   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [31:0]         cfg_data_i     = '0;

  envelope_checker     sb = new();
  int unsigned         cycles      = 0;
  int unsigned         items_sent  = 0;
  int unsigned         burst_left  = 0;
  int unsigned         stall_pct   = 0;
  int unsigned         stall_left  = 0;

  state_envelope_deframer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog, plus a fresh receiver stall rate whenever the low eight bits of the cycle count wrap to zero.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles[7:0] == 8'd0) begin
      case ($urandom_range(4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 15;
        3:       stall_pct = 40;
        default: stall_pct = 75;
      endcase
    end
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver backpressure: stalls of random length at the current rate.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Beat monitor: inputs are noted before results are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result({m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tuser[1],
                         m_axis_tlast, m_axis_tdata[8]});
    end
  end

  // Sends one byte; entered and left at a falling edge.
  task automatic send_byte(logic [7:0] b, logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_frame(ref logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic append_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q = {q, b};
  endtask

  task automatic append_word(ref logic [7:0] q[$], input logic [31:0] w);
    for (int i = 0; i < 4; i++) append_byte(q, w[8*i +: 8]);
  endtask

  task automatic fill_random(ref logic [7:0] q[$], input int unsigned n);
    repeat (n) append_byte(q, 8'($urandom));
  endtask

  // Mostly short sections, now and then a longer one.
  function automatic int unsigned pick_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(4);
  endfunction

  // Builds one frame: mostly well formed, the rest broken or plain noise.
  task automatic random_frame(ref logic [7:0] q[$]);
    int unsigned kind;
    int unsigned comp_len;
    int unsigned ctrl_len;
    int unsigned keep;
    q.delete();
    kind = $urandom_range(99);
    if (kind >= 92) begin
      fill_random(q, $urandom_range(8, 1));
      return;
    end
    comp_len = pick_len();
    ctrl_len = pick_len();
    // A length far beyond what follows, so the frame ends inside a payload.
    if (kind >= 86) begin
      if ($urandom_range(1) == 0) comp_len = $urandom | 32'h0000_0100;
      else ctrl_len = $urandom | 32'h0000_0100;
    end
    append_word(q, sb.magic);
    append_byte(q, sb.version);
    append_word(q, comp_len);
    if (comp_len > MaxLen) begin
      fill_random(q, $urandom_range(6));
      return;
    end
    fill_random(q, comp_len);
    append_word(q, ctrl_len);
    if (ctrl_len > MaxLen) begin
      fill_random(q, $urandom_range(6));
      return;
    end
    fill_random(q, ctrl_len);
    if (kind >= 80) begin
      q[4] = q[4] ^ 8'($urandom_range(255, 1));
    end else if (kind >= 74) begin
      keep = $urandom_range(3);
      q[keep] = q[keep] ^ 8'($urandom_range(255, 1));
    end else if (kind >= 66) begin
      fill_random(q, $urandom_range(3, 1));
    end else if (kind >= 58) begin
      keep = $urandom_range(q.size() - 1, 1);
      while (q.size() > keep) void'(q.pop_back());
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Stops sending and lets every outstanding result arrive.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0]  frame[$];
    int unsigned target;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty component, one controller byte, then a stray byte.
    frame.delete();
    append_word(frame, MagicReset);
    append_byte(frame, VersionReset);
    append_word(frame, 32'd0);
    append_word(frame, 32'd1);
    append_byte(frame, 8'hFF);
    append_byte(frame, 8'h00);
    send_frame(frame);

    // Directed: wrong first magic byte, the rest is ignored.
    frame.delete();
    append_byte(frame, 8'h00);
    append_byte(frame, 8'hFF);
    send_frame(frame);

    // Directed: good magic, wrong version on the final byte.
    frame.delete();
    append_word(frame, MagicReset);
    append_byte(frame, VersionReset ^ 8'hFF);
    send_frame(frame);

    // Directed: a frame that ends on its first byte.
    frame.delete();
    append_byte(frame, MagicReset[7:0]);
    send_frame(frame);

    // Random phases, each under its own register setting.
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_reg(REG_MAGIC, 32'h0000_0000);
          write_reg(REG_VERSION, {24'($urandom), 8'h00});
        end
        1: begin
          write_reg(REG_MAGIC, 32'hFFFF_FFFF);
          write_reg(REG_VERSION, 32'h0000_00FF);
        end
        2: begin
          write_reg(CfgIdxW'($urandom_range(IdxMax, REG_VERSION + 1)), $urandom);
          write_reg(REG_MAGIC, $urandom);
          write_reg(REG_VERSION, $urandom);
        end
        3: begin
          write_reg(REG_VERSION, 32'(VersionReset));
          write_reg(REG_MAGIC, MagicReset);
        end
        default: begin
          write_reg(REG_MAGIC, $urandom);
          write_reg(REG_VERSION, $urandom);
          write_reg(CfgIdxW'($urandom_range(IdxMax, REG_VERSION + 1)), $urandom);
        end
      endcase
      cfg_valid_i <= 1'b0;
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        random_frame(frame);
        send_frame(frame);
      end
    end

    wait_drained();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule : tb_state_envelope_deframer

`default_nettype wire
